// ----- hw/rtl/grffa_pkg.sv -----
// ----------------------------------------------------------------------------
// grffa_pkg
// Shared command codes and field widths of the grid region allocator.
// ----------------------------------------------------------------------------
package grffa_pkg;

	localparam int CMD_W  = 2;
	localparam int COL_W  = 4;
	localparam int ROW_W  = 2;
	localparam int SIZW_W = 4;
	localparam int SIZH_W = 3;

	typedef logic [CMD_W-1:0] cmd_t;

	localparam cmd_t CMD_ALLOC   = 2'd0;
	localparam cmd_t CMD_PLACE   = 2'd1;
	localparam cmd_t CMD_RELEASE = 2'd2;
	localparam cmd_t CMD_PROBE   = 2'd3;

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 8;

endpackage

// ----- hw/rtl/grffa_ram.sv -----
// ----------------------------------------------------------------------------
// grffa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module grffa_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 4
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/grid_region_first_fit_allocator.sv -----
// ----------------------------------------------------------------------------
// grid_region_first_fit_allocator
// Occupancy bitmap of a ROWS x COLS grid in a row-wide RAM, with first-fit
// allocate, place, release and probe of rectangles.
// ----------------------------------------------------------------------------
// Flow: release reads and rewrites each covered row; place and probe read and
//   merge each covered row, test the span, and place then rewrites the rows;
//   allocate visits start rows in turn, trying each start column, then claims.
// Throughput: one request at a time; the row RAM read/modify/write loop sets it.
// Reset: arst_n clears the state machine, output valid flag and per-row valid
//   bits, so every cell reads free right away; no clearing pass.
module grid_region_first_fit_allocator
	import grffa_pkg::*;
#(
	parameter int ROWS = 4,
	parameter int COLS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [1:0] cmd, [5:2] start_col, [7:6] start_row, [11:8] region_width,
	// [14:12] region_height, [15] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [0] ok, [4:1] found_col, [6:5] found_row, [7] zero
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CIW = (COLS > 1) ? $clog2(COLS) : 1;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CHECK = 4'd1;
	localparam logic [3:0] ST_RD    = 4'd2;
	localparam logic [3:0] ST_ACC   = 4'd3;
	localparam logic [3:0] ST_SCAN  = 4'd4;
	localparam logic [3:0] ST_WRD   = 4'd5;
	localparam logic [3:0] ST_WWR   = 4'd6;
	localparam logic [3:0] ST_DONE  = 4'd7;

	logic [3:0]        state_q;
	cmd_t              cmd_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SIZW_W-1:0] w_q;
	logic [SIZH_W-1:0] h_q;
	logic [RW-1:0]     cand_row_q;
	logic [CIW-1:0]    cand_col_q;
	logic [2:0]        cnt_q;
	logic [COLS-1:0]   union_q;
	logic              res_ok_q;
	logic [ROWS-1:0]   valid_q;
	logic [RW-1:0]     raddr_s1;

	logic              out_valid_q;
	logic              out_ok_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;

	logic [5:0]        row_sum;
	logic [RW-1:0]     row_addr;
	logic [COLS-1:0]   ram_rdata;
	logic [COLS-1:0]   row_word;
	logic [COLS-1:0]   span;
	logic              we;
	logic [COLS-1:0]   wdata;
	logic              bad;
	logic              hit;
	logic              last_col;
	logic              last_row;
	logic              last_cnt;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_row_q, out_col_q, out_ok_q};

	assign row_sum  = 6'(cand_row_q) + 6'(cnt_q);
	assign row_addr = row_sum[RW-1:0];
	assign row_word = valid_q[raddr_s1] ? ram_rdata : '0;
	assign span     = (~({COLS{1'b1}} << w_q)) << cand_col_q;
	assign hit      = ((union_q & span) == '0) || (cmd_q == CMD_RELEASE);
	assign last_col = (6'(cand_col_q) + 6'(w_q)) == 6'(COLS);
	assign last_row = (6'(cand_row_q) + 6'(h_q)) == 6'(ROWS);
	assign last_cnt = (cnt_q + 3'd1) == h_q;

	assign bad = (w_q == '0) || (h_q == '0)
		|| (6'(w_q) > 6'(COLS)) || (6'(h_q) > 6'(ROWS))
		|| ((cmd_q != CMD_ALLOC)
			&& (((6'(col_q) + 6'(w_q)) > 6'(COLS))
				|| ((6'(row_q) + 6'(h_q)) > 6'(ROWS))));

	assign we    = (state_q == ST_WWR);
	assign wdata = (cmd_q == CMD_RELEASE) ? (row_word & ~span) : (row_word | span);

	grffa_ram #(
		.WIDTH(COLS),
		.DEPTH(ROWS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(raddr_s1),
		.wdata(wdata),
		.raddr(row_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_RD || state_q == ST_WRD) begin
			raddr_s1 <= row_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			res_ok_q    <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (we) begin
				valid_q[raddr_s1] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (bad) begin
						res_ok_q <= 1'b0;
						state_q  <= ST_DONE;
					end else if (cmd_q == CMD_RELEASE) begin
						state_q <= ST_WRD;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					state_q <= last_cnt ? ST_SCAN : ST_RD;
				end
				ST_SCAN: begin
					if (hit) begin
						if (cmd_q == CMD_PROBE) begin
							res_ok_q <= 1'b1;
							state_q  <= ST_DONE;
						end else begin
							state_q <= ST_WRD;
						end
					end else if (cmd_q != CMD_ALLOC || (last_col && last_row)) begin
						res_ok_q <= 1'b0;
						state_q  <= ST_DONE;
					end else if (last_col) begin
						state_q <= ST_RD;
					end
				end
				ST_WRD: begin
					state_q <= ST_WWR;
				end
				ST_WWR: begin
					if (last_cnt) begin
						res_ok_q <= 1'b1;
						state_q  <= ST_DONE;
					end else begin
						state_q <= ST_WRD;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q <= cmd_t'(s_tdata[1:0]);
				col_q <= s_tdata[5:2];
				row_q <= s_tdata[7:6];
				w_q   <= s_tdata[11:8];
				h_q   <= s_tdata[14:12];
			end
			ST_CHECK: begin
				cand_row_q <= (cmd_q == CMD_ALLOC) ? '0 : RW'(row_q);
				cand_col_q <= (cmd_q == CMD_ALLOC) ? '0 : CIW'(col_q);
				cnt_q      <= '0;
				union_q    <= '0;
			end
			ST_ACC: begin
				union_q <= union_q | row_word;
				cnt_q   <= last_cnt ? 3'd0 : cnt_q + 3'd1;
			end
			ST_SCAN: begin
				cnt_q <= '0;
				if (!hit && last_col && !last_row) begin
					cand_row_q <= cand_row_q + RW'(1);
					cand_col_q <= '0;
					union_q    <= '0;
				end else if (!hit) begin
					cand_col_q <= cand_col_q + CIW'(1);
				end
			end
			ST_WWR: begin
				cnt_q <= cnt_q + 3'd1;
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_ok_q  <= res_ok_q;
					out_col_q <= res_ok_q ? COL_W'(cand_col_q) : '0;
					out_row_q <= res_ok_q ? ROW_W'(cand_row_q) : '0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hw/rtl/grffa_checker.sv -----
// ----------------------------------------------------------------------------
// grffa_checker
// Port-level checks of the grid region allocator, bound to the top level.
// ----------------------------------------------------------------------------
module grffa_checker
	import grffa_pkg::*;
#(
	parameter int ROWS = 4,
	parameter int COLS = 10
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	logic [1:0] pend_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("result without a request");

	a_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> pend_q != 2'd2)
		else $error("request taken with two outstanding");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[6:1] == 6'd0)
		else $error("failed result carries a position");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> (32'(m_tdata[6:5]) < ROWS) && (32'(m_tdata[4:1]) < COLS))
		else $error("position outside grid");

endmodule

bind grid_region_first_fit_allocator grffa_checker #(
	.ROWS(ROWS),
	.COLS(COLS)
) u_grffa_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
